### rtl/biq_pkg.sv
// ----------------------------------------------------------------------------
// biq_pkg: shared constants, types and helpers of the biquad low-pass core
// Holds the fixed-point widths, the coefficient constants and the divider
// request/status structures.
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int SampleWidth  = 24;
  localparam int HistExtra    = 8;
  localparam int HistWidth    = SampleWidth + HistExtra;
  localparam int CoefFracBits = 28;
  localparam int CoefWidth    = 32;
  localparam int RegWidth     = 24;
  localparam int KFrac        = 20;
  localparam int DenWidth     = 62;
  localparam int DivSteps     = CoefFracBits + 2;
  localparam int DivCntWidth  = $clog2(DivSteps);
  localparam int QuoWidth     = DivSteps;
  localparam int MulWidth     = 33;
  localparam int ProdWidth    = 2 * MulWidth;

  localparam logic [RegWidth-1:0] CutoffReset = 24'd16085;
  localparam logic [RegWidth-1:0] PeriodReset = 24'd16777;

  localparam logic [MulWidth-1:0] Kc2500 = 33'd2500;
  localparam logic [MulWidth-1:0] Kc7071 = 33'd7071;
  localparam logic [DenWidth-1:0] CTerm   = DenWidth'(10000) << (2 * KFrac);
  localparam logic [DenWidth-1:0] PosTerm = DenWidth'(20000) << (2 * KFrac);

  localparam logic [1:0] ModeFilter = 2'd0;
  localparam logic [1:0] ModeClear  = 2'd1;
  localparam logic [1:0] ModePreset = 2'd2;

  localparam logic [1:0] RegCutoff = 2'd0;
  localparam logic [1:0] RegPeriod = 2'd1;

  typedef struct packed {
    logic start;
    logic neg;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Saturate a 39-bit signed value to the 32-bit history range.
  function automatic logic signed [HistWidth-1:0] sat_hist(input logic signed [38:0] v);
    logic signed [38:0] hi;
    logic signed [38:0] lo;
    hi = 39'sd2147483647;
    lo = -39'sd2147483648;
    if (v > hi) return HistWidth'(hi);
    else if (v < lo) return HistWidth'(lo);
    else return v[HistWidth-1:0];
  endfunction

  // Saturate a 25-bit signed value to the sample range.
  function automatic logic signed [SampleWidth-1:0] sat_sample(
      input logic signed [SampleWidth:0] v);
    if (v[SampleWidth] != v[SampleWidth-1]) begin
      return v[SampleWidth] ? {1'b1, {(SampleWidth-1){1'b0}}}
                            : {1'b0, {(SampleWidth-1){1'b1}}};
    end
    return v[SampleWidth-1:0];
  endfunction

endpackage

### rtl/biq_divider.sv
// ----------------------------------------------------------------------------
// biq_divider: restoring divider for the coefficient quotients
// Produces round(mag * 2^28 / den) with sign, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module biq_divider (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  biq_pkg::div_req_t                     req_i,
  input  logic [biq_pkg::DenWidth-1:0]          mag_i,
  input  logic [biq_pkg::DenWidth-1:0]          den_i,
  output biq_pkg::div_stat_t                    stat_o,
  output logic signed [biq_pkg::CoefWidth-1:0]  coef_o
);
  import biq_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic                   neg_q, neg_d;
  logic [DivCntWidth-1:0] cnt_q, cnt_d;
  logic [DenWidth-1:0]    rem_q, rem_d;
  logic [DenWidth-1:0]    den_q, den_d;
  logic [QuoWidth-1:0]    quo_q, quo_d;
  logic                   ge;
  logic [DenWidth-1:0]    diff;
  logic [QuoWidth:0]      rounded;
  logic [CoefWidth-1:0]   mag_coef;

  assign ge   = rem_q >= den_q;
  assign diff = ge ? (rem_q - den_q) : rem_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      neg_d  = req_i.neg;
      cnt_d  = '0;
      rem_d  = mag_i;
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[QuoWidth-2:0], ge};
      rem_d = {diff[DenWidth-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntWidth'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  // The quotient carries one guard bit; the numerator is below twice the
  // denominator, so the rounded magnitude never exceeds 2^29.
  assign rounded  = ({1'b0, quo_q} + 1'b1) >> 1;
  assign mag_coef = CoefWidth'(rounded);
  assign coef_o   = neg_q ? -$signed(mag_coef) : $signed(mag_coef);
  assign stat_o   = '{busy: busy_q, done: done_q};

endmodule

### rtl/second_order_lowpass_iir_core.sv
// ----------------------------------------------------------------------------
// second_order_lowpass_iir_core: Butterworth biquad low-pass filter
// Derives five Q4.28 coefficients from cutoff and sample period, then
// filters 24-bit samples with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// A filter item passes through acceptance, five multiply-accumulate steps
// on the single 33x33 multiplier, one rounding step and the loading of the
// output register, which waits while the output is stalled; a clear, preset
// or no-op item goes from acceptance straight to loading the output register;
// the next item is taken once the block is idle again.
// After reset, and after each write to the cutoff or period register, the
// coefficients are recomputed: setup steps for k, its square and the a and b
// terms on the same multiplier, then the denominator, followed by five
// restoring divisions, during which no input or configuration transfer is
// taken.
module second_order_lowpass_iir_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             mode_i,
  input  logic signed [biq_pkg::SampleWidth-1:0] sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [biq_pkg::SampleWidth-1:0] filtered_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [1:0]                             cfg_index_i,
  input  logic [biq_pkg::RegWidth-1:0]           cfg_data_i
);
  import biq_pkg::*;

  // Sequencer states.
  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SKProd  = 4'd1;
  localparam logic [3:0] SSquare = 4'd2;
  localparam logic [3:0] SALow   = 4'd3;
  localparam logic [3:0] SAHigh  = 4'd4;
  localparam logic [3:0] SBTerm  = 4'd5;
  localparam logic [3:0] SDen    = 4'd6;
  localparam logic [3:0] SDStart = 4'd7;
  localparam logic [3:0] SDWait  = 4'd8;
  localparam logic [3:0] SMac    = 4'd9;
  localparam logic [3:0] SRound  = 4'd10;
  localparam logic [3:0] SFinish = 4'd11;

  logic [3:0] state_q, state_d;

  logic [RegWidth-1:0] cutoff_q, cutoff_d;
  logic [RegWidth-1:0] period_q, period_d;

  // Derivation registers.
  logic [RegWidth-1:0]     k_q, k_d;
  logic [2*RegWidth-1:0]   ksq_q, ksq_d;
  logic [DenWidth-1:0]     a_q, a_d;
  logic [DenWidth-1:0]     b_q, b_d;
  logic [DenWidth-1:0]     den_q, den_d;
  logic [2:0]              cidx_q, cidx_d;
  logic signed [CoefWidth-1:0] coef_q [5];

  // Filter state.
  logic signed [SampleWidth-1:0] x_q, x_d;
  logic signed [SampleWidth-1:0] ih0_q, ih0_d, ih1_q, ih1_d;
  logic signed [HistWidth-1:0]   oh0_q, oh0_d, oh1_q, oh1_d;
  logic signed [SampleWidth-1:0] last_q, last_d;
  logic signed [ProdWidth-1:0]   acc_q, acc_d;
  logic [2:0]                    tap_q, tap_d;

  logic                          out_valid_q, out_valid_d;
  logic signed [SampleWidth-1:0] filtered_q, filtered_d;

  // Shared multiplier.
  logic signed [MulWidth-1:0]  mul_a, mul_b;
  logic signed [ProdWidth-1:0] prod;
  logic signed [HistWidth-1:0] hist_sel;

  // Divider link.
  div_req_t                    div_req;
  div_stat_t                   div_stat;
  logic [DenWidth-1:0]         div_mag;
  logic signed [CoefWidth-1:0] div_coef;
  logic                        coef_we;

  logic                        in_xfer, cfg_xfer, out_free;
  logic signed [ProdWidth:0]   acc_rnd;
  logic signed [38:0]          y_full;
  logic signed [HistWidth-1:0] y_sat;
  logic signed [HistWidth:0]   y_rnd;
  logic [2*RegWidth-1:0]       kprod;
  logic [DenWidth-1:0]         a2;
  logic [DenWidth-1:0]         ac;

  // A pending register write takes precedence over an input item, so the
  // input is stalled in that cycle rather than silently passed over.
  assign in_stall_o  = (state_q != SIdle) || cfg_valid_i;
  assign cfg_ready_o = state_q == SIdle;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;

  // History tap feeding the multiplier; inputs carry the extra fraction bits.
  always_comb begin
    case (tap_q)
      3'd0:    hist_sel = {x_q, {HistExtra{1'b0}}};
      3'd1:    hist_sel = {ih0_q, {HistExtra{1'b0}}};
      3'd2:    hist_sel = {ih1_q, {HistExtra{1'b0}}};
      3'd3:    hist_sel = oh0_q;
      default: hist_sel = oh1_q;
    endcase
  end

  // Operand selection for the one multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      SKProd: begin
        mul_a = $signed({{(MulWidth-RegWidth){1'b0}}, cutoff_q});
        mul_b = $signed({{(MulWidth-RegWidth){1'b0}}, period_q});
      end
      SSquare: begin
        mul_a = $signed({{(MulWidth-RegWidth){1'b0}}, k_q});
        mul_b = $signed({{(MulWidth-RegWidth){1'b0}}, k_q});
      end
      SALow: begin
        mul_a = $signed(Kc2500);
        mul_b = $signed({{(MulWidth-RegWidth){1'b0}}, ksq_q[RegWidth-1:0]});
      end
      SAHigh: begin
        mul_a = $signed(Kc2500);
        mul_b = $signed({{(MulWidth-RegWidth){1'b0}}, ksq_q[2*RegWidth-1:RegWidth]});
      end
      SBTerm: begin
        mul_a = $signed(Kc7071);
        mul_b = $signed({{(MulWidth-RegWidth){1'b0}}, k_q});
      end
      SMac: begin
        mul_a = MulWidth'(coef_q[tap_q]);
        mul_b = MulWidth'(hist_sel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign kprod = prod[2*RegWidth-1:0];
  assign a2    = {a_q[DenWidth-2:0], 1'b0};
  assign ac    = a_q + CTerm;

  // Numerator and sign for the coefficient in turn: b0, b1, b2, a1, a2.
  always_comb begin
    div_mag = a_q;
    div_req = '{start: 1'b0, neg: 1'b0};
    case (cidx_q)
      3'd0, 3'd2: div_mag = a_q;
      3'd1:       div_mag = a2;
      3'd3: begin
        if (PosTerm >= a2) begin
          div_mag = PosTerm - a2;
        end else begin
          div_mag     = a2 - PosTerm;
          div_req.neg = 1'b1;
        end
      end
      default: begin
        if (b_q >= ac) begin
          div_mag = b_q - ac;
        end else begin
          div_mag     = ac - b_q;
          div_req.neg = 1'b1;
        end
      end
    endcase
    div_req.start = state_q == SDStart;
  end

  biq_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .mag_i  (div_mag),
    .den_i  (den_q),
    .stat_o (div_stat),
    .coef_o (div_coef)
  );

  // Output rounding: Q.28 accumulator to history with 8 fraction bits, then
  // to the plain sample; both round half up and saturate.
  assign acc_rnd = {acc_q[ProdWidth-1], acc_q} + (ProdWidth+1)'(1 << (CoefFracBits - 1));
  assign y_full  = 39'(acc_rnd >>> CoefFracBits);
  assign y_sat   = sat_hist(y_full);
  assign y_rnd   = {y_sat[HistWidth-1], y_sat} + (HistWidth+1)'(1 << (HistExtra - 1));

  always_comb begin
    state_d     = state_q;
    cutoff_d    = cutoff_q;
    period_d    = period_q;
    k_d         = k_q;
    ksq_d       = ksq_q;
    a_d         = a_q;
    b_d         = b_q;
    den_d       = den_q;
    cidx_d      = cidx_q;
    coef_we     = 1'b0;
    x_d         = x_q;
    ih0_d       = ih0_q;
    ih1_d       = ih1_q;
    oh0_d       = oh0_q;
    oh1_d       = oh1_q;
    last_d      = last_q;
    acc_d       = acc_q;
    tap_d       = tap_q;
    out_valid_d = out_valid_q && out_stall_i;
    filtered_d  = filtered_q;

    unique case (state_q)
      SIdle: begin
        if (cfg_xfer) begin
          if (cfg_index_i == RegCutoff) begin
            cutoff_d = cfg_data_i;
            state_d  = SKProd;
          end else if (cfg_index_i == RegPeriod) begin
            period_d = cfg_data_i;
            state_d  = SKProd;
          end
        end else if (in_xfer) begin
          x_d     = sample_i;
          acc_d   = '0;
          tap_d   = '0;
          state_d = SFinish;
          case (mode_i)
            ModeFilter: state_d = SMac;
            ModeClear: begin
              ih0_d = '0;
              ih1_d = '0;
              oh0_d = '0;
              oh1_d = '0;
            end
            ModePreset: begin
              ih0_d = sample_i;
              ih1_d = sample_i;
              oh0_d = {sample_i, {HistExtra{1'b0}}};
              oh1_d = {sample_i, {HistExtra{1'b0}}};
            end
            default: ;
          endcase
        end
      end
      SKProd: begin
        // k in Q4.20, saturated when the product overflows four integer bits.
        if (kprod[2*RegWidth-1:RegWidth+(32-KFrac)] != '0) begin
          k_d = '1;
        end else begin
          k_d = kprod[RegWidth+(32-KFrac)-1:32-KFrac];
        end
        state_d = SSquare;
      end
      SSquare: begin
        ksq_d   = kprod;
        state_d = SALow;
      end
      SALow: begin
        a_d     = DenWidth'(prod);
        state_d = SAHigh;
      end
      SAHigh: begin
        a_d     = a_q + (DenWidth'(prod) << RegWidth);
        state_d = SBTerm;
      end
      SBTerm: begin
        b_d     = DenWidth'(prod) << KFrac;
        state_d = SDen;
      end
      SDen: begin
        den_d   = a_q + b_q + CTerm;
        cidx_d  = '0;
        state_d = SDStart;
      end
      SDStart: begin
        state_d = SDWait;
      end
      SDWait: begin
        if (div_stat.done) begin
          coef_we = 1'b1;
          if (cidx_q == 3'd4) begin
            state_d = SIdle;
          end else begin
            cidx_d  = cidx_q + 1'b1;
            state_d = SDStart;
          end
        end
      end
      SMac: begin
        acc_d = acc_q + prod;
        tap_d = tap_q + 1'b1;
        if (tap_q == 3'd4) begin
          state_d = SRound;
        end
      end
      SRound: begin
        ih1_d   = ih0_q;
        ih0_d   = x_q;
        oh1_d   = oh0_q;
        oh0_d   = y_sat;
        last_d  = sat_sample((SampleWidth+1)'(y_rnd >>> HistExtra));
        state_d = SFinish;
      end
      SFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          filtered_d  = last_q;
          state_d     = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SKProd;
      cutoff_q    <= CutoffReset;
      period_q    <= PeriodReset;
      ih0_q       <= '0;
      ih1_q       <= '0;
      oh0_q       <= '0;
      oh1_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      cidx_q      <= '0;
      tap_q       <= '0;
    end else begin
      state_q     <= state_d;
      cutoff_q    <= cutoff_d;
      period_q    <= period_d;
      ih0_q       <= ih0_d;
      ih1_q       <= ih1_d;
      oh0_q       <= oh0_d;
      oh1_q       <= oh1_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      cidx_q      <= cidx_d;
      tap_q       <= tap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    ksq_q      <= ksq_d;
    a_q        <= a_d;
    b_q        <= b_d;
    den_q      <= den_d;
    x_q        <= x_d;
    acc_q      <= acc_d;
    filtered_q <= filtered_d;
    if (coef_we) begin
      coef_q[cidx_q] <= div_coef;
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Biquad low-pass core testbench
// Drives filter, clear, preset and no-op items under several cutoff and
// period settings, predicts every result and checks it in order.
// ----------------------------------------------------------------------------

class lowpass_scoreboard;
  // Register copies and derived Q4.28 coefficients: b0, b1, b2, a1, a2.
  logic [23:0]        cutoff_reg;
  logic [23:0]        period_reg;
  logic signed [31:0] coef [5];
  // Filter histories: inputs as plain samples, outputs with 8 extra fraction bits.
  logic signed [23:0] x_hist [2];
  logic signed [31:0] y_hist [2];
  logic signed [23:0] last_out;
  logic signed [23:0] expected_q [$];
  int                 errors;

  function new();
    cutoff_reg = biq_pkg::CutoffReset;
    period_reg = biq_pkg::PeriodReset;
    x_hist[0] = '0; x_hist[1] = '0;
    y_hist[0] = '0; y_hist[1] = '0;
    last_out = '0;
    errors = 0;
    update_coefficients();
  endfunction

  // Long division with one guard bit, rounded half away from zero, then
  // limited to the 32-bit signed range.
  function logic signed [31:0] rounded_ratio(bit neg, longint unsigned num,
                                             longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    longint          v;
    q = num / den;
    r = num % den;
    for (int i = 0; i < 29; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    q = (q + 64'd1) >> 1;
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    v = neg ? -longint'(q) : longint'(q);
    if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
    return v[31:0];
  endfunction

  function void update_coefficients();
    longint unsigned k, a, b, c, den, pos, negp;
    k = (64'(cutoff_reg) * 64'(period_reg)) >> 12;
    if (k > 64'hFF_FFFF) k = 64'hFF_FFFF;
    a = 64'd2500 * k * k;
    b = 64'd7071 * (k << 20);
    c = 64'd10000 << 40;
    den = a + b + c;
    coef[0] = rounded_ratio(1'b0, a, den);
    coef[1] = rounded_ratio(1'b0, 2 * a, den);
    coef[2] = coef[0];
    pos = 64'd20000 << 40;
    negp = 2 * a;
    coef[3] = pos >= negp ? rounded_ratio(1'b0, pos - negp, den)
                          : rounded_ratio(1'b1, negp - pos, den);
    pos = b;
    negp = a + c;
    coef[4] = pos >= negp ? rounded_ratio(1'b0, pos - negp, den)
                          : rounded_ratio(1'b1, negp - pos, den);
  endfunction

  function void note_register(logic [1:0] index, logic [23:0] data);
    if (index == biq_pkg::RegCutoff) begin
      cutoff_reg = data;
      update_coefficients();
    end else if (index == biq_pkg::RegPeriod) begin
      period_reg = data;
      update_coefficients();
    end
  endfunction

  // Notes an accepted input transfer and queues the filtered value it yields.
  function void note_input(logic [1:0] mode, logic signed [23:0] sample);
    logic signed [95:0] acc;
    logic signed [95:0] y;
    logic signed [95:0] r;
    if (mode == biq_pkg::ModeFilter) begin
      acc = 96'(coef[0]) * (96'(sample) * 256)
          + 96'(coef[1]) * (96'(x_hist[0]) * 256)
          + 96'(coef[2]) * (96'(x_hist[1]) * 256)
          + 96'(coef[3]) * 96'(y_hist[0])
          + 96'(coef[4]) * 96'(y_hist[1]);
      y = (acc + (96'sd1 <<< 27)) >>> 28;
      if (y > 96'sh7FFF_FFFF) y = 96'sh7FFF_FFFF;
      else if (y < -96'sh8000_0000) y = -96'sh8000_0000;
      x_hist[1] = x_hist[0];
      x_hist[0] = sample;
      y_hist[1] = y_hist[0];
      y_hist[0] = y[31:0];
      r = (y + 96'sd128) >>> 8;
      if (r > 96'sh7F_FFFF) r = 96'sh7F_FFFF;
      else if (r < -96'sh80_0000) r = -96'sh80_0000;
      last_out = r[23:0];
    end else if (mode == biq_pkg::ModeClear) begin
      x_hist[0] = '0; x_hist[1] = '0;
      y_hist[0] = '0; y_hist[1] = '0;
    end else if (mode == biq_pkg::ModePreset) begin
      x_hist[0] = sample; x_hist[1] = sample;
      y_hist[0] = 32'(sample) * 256;
      y_hist[1] = 32'(sample) * 256;
    end
    expected_q = {expected_q, last_out};
  endfunction

  function void check_result(logic signed [23:0] filtered);
    logic signed [23:0] want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: filtered %0d", filtered);
      return;
    end
    want = expected_q.pop_front();
    if (filtered !== want) begin
      errors++;
      if (errors <= 10)
        $display("filtered mismatch: expected %0d, got %0d", want, filtered);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module testbench;
  import biq_pkg::*;

  // Mode 3 is a no-op and register indexes above 1 are ignored by the block.
  localparam logic [1:0] ModeNoOp  = 2'd3;
  localparam logic [1:0] RegSpareA = 2'd2;
  localparam logic [1:0] RegSpareB = 2'd3;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [1:0]                    mode_i;
  logic signed [SampleWidth-1:0] sample_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic signed [SampleWidth-1:0] filtered_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [1:0]                    cfg_index_i;
  logic [RegWidth-1:0]           cfg_data_i;

  lowpass_scoreboard sb;
  // When clear, neither the sender nor the receiver inserts idle bursts.
  bit idling_on;

  second_order_lowpass_iir_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The watchdog allows for the slowest legal run several times over.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver side: the stall changes on the falling edge, in random bursts
  // while idling is enabled, and stays low otherwise.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Results are sampled at the rising edge, where the block's outputs still
  // hold their values from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(filtered_o);
  end

  // Presents one item and holds it until the transfer completes; afterwards
  // the sender may idle for a random burst.
  task automatic send_item(input logic [1:0] mode, input logic signed [23:0] sample);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    sample_i   <= sample;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(mode, sample);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 14)) @(negedge clk_i);
    end
  endtask

  task automatic write_register(input logic [1:0] index, input logic [23:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_register(index, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Lets every expected result arrive, then gives the block time to settle
  // before a register write.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Mostly filter items with mixed sample sizes; clears, presets and no-ops
  // are sprinkled in to break the histories now and then.
  task automatic random_items(input int count);
    int pick;
    logic signed [23:0] s;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: s = 24'($urandom);
        1: s = 24'($signed($urandom_range(0, 2000)) - 1000);
        2: s = $urandom_range(0, 1) ? 24'sh7F_FFFF : -24'sh80_0000;
        default: s = 24'($signed($urandom_range(0, 200000)) - 100000);
      endcase
      if (pick < 88) send_item(ModeFilter, s);
      else if (pick < 93) send_item(ModePreset, s);
      else if (pick < 97) send_item(ModeClear, s);
      else send_item(ModeNoOp, s);
    end
  endtask

  initial begin
    sb = new();
    idling_on   = 1'b1;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = ModeFilter;
    sample_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegCutoff;
    cfg_data_i  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items under the reset setting: field extremes, every mode,
    // a no-op, and a preset followed by filtering to check settling.
    send_item(ModeFilter, 24'sh7F_FFFF);
    send_item(ModeFilter, 24'sh7F_FFFF);
    send_item(ModeFilter, -24'sh80_0000);
    send_item(ModeFilter, '0);
    send_item(ModeNoOp, 24'sh12_3456);
    send_item(ModeClear, -24'sd1);
    send_item(ModeFilter, 24'sd1);
    send_item(ModeFilter, -24'sd1);
    send_item(ModePreset, 24'sh7F_FFFF);
    send_item(ModeFilter, 24'sh7F_FFFF);
    send_item(ModeFilter, -24'sh80_0000);
    send_item(ModePreset, -24'sh80_0000);
    send_item(ModeFilter, -24'sh80_0000);
    send_item(ModeFilter, 24'sh55_5555);
    send_item(ModeFilter, -24'sh55_5556);
    send_item(ModeClear, '0);
    send_item(ModeFilter, 24'sh00_1000);
    send_item(ModeNoOp, -24'sh80_0000);
    drain();

    // Largest k: both registers at full scale drive k into saturation.
    write_register(RegCutoff, 24'hFF_FFFF);
    write_register(RegPeriod, 24'hFF_FFFF);
    random_items(200);
    drain();

    // Smallest nonzero registers give k = 0 after truncation.
    write_register(RegCutoff, 24'd1);
    write_register(RegPeriod, 24'd1);
    random_items(150);
    drain();

    // A zero register, plus writes to unused indexes which must change nothing.
    write_register(RegCutoff, 24'd0);
    write_register(RegSpareA, 24'hAB_CDEF);
    write_register(RegSpareB, 24'h12_3456);
    random_items(100);
    drain();

    // Several random settings, mostly with k in a sensible range.
    for (int p = 0; p < 7; p++) begin
      write_register(RegCutoff,
                     24'(p[0] ? $urandom : $urandom_range(1, 24'h10_0000)));
      write_register(RegPeriod,
                     24'(p[1] ? $urandom : $urandom_range(1, 24'h01_0000)));
      random_items(180);
      drain();
    end

    // Back to the reset setting, last part without any idling.
    write_register(RegCutoff, CutoffReset);
    write_register(RegPeriod, PeriodReset);
    idling_on = 1'b0;
    random_items(240);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
